[rtl/bchc_pkg.sv]
// Shared types, codes and reset constants of the button click/hold classifier.
`timescale 1ns / 1ps

package bchc_pkg;

    // Default width of the stored time stamps.
    localparam int TIME_BITS_DEFAULT = 32;

    // Widths of the stream payload fields.
    localparam int NOW_BITS     = 32;
    localparam int THRESH_BITS  = 15;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 8;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 16;

    // Event codes reported for every sample.
    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_CLICK     = 3'd1,
        EV_DOUBLE    = 3'd2,
        EV_HOLD      = 3'd3,
        EV_LONG_HOLD = 3'd4
    } evt_code_t;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DC_GAP    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD      = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_HOLD = 8'd3;

    // Reset values of the thresholds in milliseconds.
    localparam logic [THRESH_BITS-1:0] DEBOUNCE_RST  = 15'd20;
    localparam logic [THRESH_BITS-1:0] DC_GAP_RST    = 15'd250;
    localparam logic [THRESH_BITS-1:0] HOLD_RST      = 15'd1000;
    localparam logic [THRESH_BITS-1:0] LONG_HOLD_RST = 15'd3000;

    // Threshold registers handed to the classifier core.
    typedef struct packed {
        logic [THRESH_BITS-1:0] debounce_ms;
        logic [THRESH_BITS-1:0] double_click_gap_ms;
        logic [THRESH_BITS-1:0] hold_ms;
        logic [THRESH_BITS-1:0] long_hold_ms;
    } cfg_t;

    // Classifier status flags.
    typedef struct packed {
        logic dc_waiting;
        logic dc_on_release;
        logic single_allowed;
        logic ignore_release;
        logic hold_reported;
        logic long_hold_reported;
    } flags_t;

    localparam flags_t FLAGS_RST = '{
        dc_waiting:         1'b0,
        dc_on_release:      1'b0,
        single_allowed:     1'b1,
        ignore_release:     1'b0,
        hold_reported:      1'b0,
        long_hold_reported: 1'b0
    };

endpackage

[rtl/button_click_hold_classifier.sv]
// Top level: stream ports, threshold registers and the two-stage pipeline.
// A sample passes the input register, then the result register, where its event waits for m_tready.
// Throughput: one sample per cycle unless the result stream holds back; the input register
// and the result register each hold one item, and the state update sits between them.
// Reset (rst_n low, asynchronous) empties both stages, sets thresholds to 20, 250,
// 1000 and 3000 ms, marks the button released and both edge times all ones.
`timescale 1ns / 1ps

module button_click_hold_classifier #(
    parameter int TIME_BITS = bchc_pkg::TIME_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input stream; s_tdata: [0] level, [32:1] now_ms, [39:33] zero.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bchc_pkg::IN_TDATA_W-1:0]  s_tdata,
    // Result stream; m_tdata: [2:0] event_res, [7:3] zero.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bchc_pkg::OUT_TDATA_W-1:0] m_tdata,
    // Threshold write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bchc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bchc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    bchc_pkg::cfg_t                 cfg_reg;
    logic                           s1_valid_reg;
    logic                           s1_level_reg;
    logic [bchc_pkg::NOW_BITS-1:0]  s1_now_reg;
    logic                           out_valid_reg;
    bchc_pkg::evt_code_t            out_evt_reg;
    bchc_pkg::evt_code_t            evt;
    logic                           s1_advance;
    logic                           in_xfer;
    logic [bchc_pkg::THRESH_BITS-1:0] cfg_val;

    // Handshake control.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign in_xfer    = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_val    = cfg_data[bchc_pkg::THRESH_BITS-1:0];

    // Threshold registers; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms         <= bchc_pkg::DEBOUNCE_RST;
            cfg_reg.double_click_gap_ms <= bchc_pkg::DC_GAP_RST;
            cfg_reg.hold_ms             <= bchc_pkg::HOLD_RST;
            cfg_reg.long_hold_ms        <= bchc_pkg::LONG_HOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bchc_pkg::REG_DEBOUNCE:  cfg_reg.debounce_ms         <= cfg_val;
                bchc_pkg::REG_DC_GAP:    cfg_reg.double_click_gap_ms <= cfg_val;
                bchc_pkg::REG_HOLD:      cfg_reg.hold_ms             <= cfg_val;
                bchc_pkg::REG_LONG_HOLD: cfg_reg.long_hold_ms        <= cfg_val;
                default:                 cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_level_reg <= s_tdata[0];
            s1_now_reg   <= s_tdata[bchc_pkg::NOW_BITS:1];
        end
    end

    bchc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_advance),
        .level  (s1_level_reg),
        .now_ms (s1_now_reg),
        .cfg    (cfg_reg),
        .evt    (evt)
    );

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_evt_reg <= evt;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(bchc_pkg::OUT_TDATA_W - 3){1'b0}}, out_evt_reg};

`ifndef NO_ASSERTIONS
    // An accepted sample occupies the input register next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> s1_valid_reg)
        else $error("accepted sample lost");

    // Input stalls only when both stages are full and the result is not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> s1_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without back pressure");

    // A processed sample always shows up as a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> m_tvalid)
        else $error("processed sample gave no result");
`endif

endmodule

[rtl/bchc_core.sv]
// Classifier state and the per-sample event decision.
`timescale 1ns / 1ps

module bchc_core #(
    parameter int TIME_BITS = bchc_pkg::TIME_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          level,
    input  logic [bchc_pkg::NOW_BITS-1:0] now_ms,
    input  bchc_pkg::cfg_t                cfg,
    output bchc_pkg::evt_code_t           evt
);

    logic                  last_level_reg;
    logic [TIME_BITS-1:0]  press_time_reg;
    logic [TIME_BITS-1:0]  press_time_next;
    logic [TIME_BITS-1:0]  release_time_reg;
    logic [TIME_BITS-1:0]  release_time_next;
    bchc_pkg::flags_t      flags_reg;
    bchc_pkg::flags_t      flags_next;

    logic [TIME_BITS-1:0]  now_w;
    logic [TIME_BITS-1:0]  deb_w;
    logic [TIME_BITS-1:0]  gap_w;
    logic [TIME_BITS-1:0]  hold_w;
    logic [TIME_BITS-1:0]  long_w;
    logic [TIME_BITS-1:0]  since_rel_old;
    logic [TIME_BITS-1:0]  since_press_old;
    logic [TIME_BITS-1:0]  since_rel_new;
    logic [TIME_BITS-1:0]  since_press_new;

    // Time stamp and thresholds brought to the stored time width.
    assign now_w  = TIME_BITS'(now_ms);
    assign deb_w  = TIME_BITS'(cfg.debounce_ms);
    assign gap_w  = TIME_BITS'(cfg.double_click_gap_ms);
    assign hold_w = TIME_BITS'(cfg.hold_ms);
    assign long_w = TIME_BITS'(cfg.long_hold_ms);

    // Edge qualification, then click, then hold tests, in that order.
    always_comb
    begin
        press_time_next   = press_time_reg;
        release_time_next = release_time_reg;
        flags_next        = flags_reg;
        evt               = bchc_pkg::EV_NONE;
        since_rel_old     = now_w - release_time_reg;
        since_press_old   = now_w - press_time_reg;

        if (!level && last_level_reg && (since_rel_old > deb_w))
        begin
            // Qualified press edge.
            press_time_next               = now_w;
            flags_next.ignore_release     = 1'b0;
            flags_next.single_allowed     = 1'b1;
            flags_next.hold_reported      = 1'b0;
            flags_next.long_hold_reported = 1'b0;
            flags_next.dc_on_release      = (since_rel_old < gap_w) &&
                                            !flags_reg.dc_on_release &&
                                            flags_reg.dc_waiting;
            flags_next.dc_waiting         = 1'b0;
        end
        else if (level && !last_level_reg && (since_press_old > deb_w))
        begin
            // Qualified release edge, dropped after a hold.
            if (!flags_reg.ignore_release)
            begin
                release_time_next = now_w;
                if (!flags_reg.dc_on_release)
                begin
                    flags_next.dc_waiting = 1'b1;
                end
                else
                begin
                    evt                       = bchc_pkg::EV_DOUBLE;
                    flags_next.dc_on_release  = 1'b0;
                    flags_next.dc_waiting     = 1'b0;
                    flags_next.single_allowed = 1'b0;
                end
            end
        end

        since_rel_new   = now_w - release_time_next;
        since_press_new = now_w - press_time_next;

        // A single click once the double-click window has closed.
        if (level && (since_rel_new >= gap_w) && flags_next.dc_waiting &&
            !flags_next.dc_on_release && flags_next.single_allowed &&
            (evt != bchc_pkg::EV_DOUBLE))
        begin
            evt                   = bchc_pkg::EV_CLICK;
            flags_next.dc_waiting = 1'b0;
        end

        // Hold and long hold while the button stays down.
        if (!level && (since_press_new >= hold_w))
        begin
            if (!flags_next.hold_reported)
            begin
                evt                       = bchc_pkg::EV_HOLD;
                flags_next.ignore_release = 1'b1;
                flags_next.dc_on_release  = 1'b0;
                flags_next.dc_waiting     = 1'b0;
                flags_next.hold_reported  = 1'b1;
            end
            if ((since_press_new >= long_w) && !flags_next.long_hold_reported)
            begin
                evt                           = bchc_pkg::EV_LONG_HOLD;
                flags_next.long_hold_reported = 1'b1;
            end
        end
    end

    // State update on each processed sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg   <= 1'b1;
            press_time_reg   <= '1;
            release_time_reg <= '1;
            flags_reg        <= bchc_pkg::FLAGS_RST;
        end
        else if (step)
        begin
            last_level_reg   <= level;
            press_time_reg   <= press_time_next;
            release_time_reg <= release_time_next;
            flags_reg        <= flags_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A long hold leaves both hold marks set.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && (evt == bchc_pkg::EV_LONG_HOLD)
        |=> flags_reg.hold_reported && flags_reg.long_hold_reported)
        else $error("long hold without both hold marks");

    // A double click closes the pending click.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && (evt == bchc_pkg::EV_DOUBLE)
        |=> !flags_reg.single_allowed && !flags_reg.dc_waiting)
        else $error("double click left a click pending");

    // The previous level follows every processed sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (last_level_reg == $past(level)))
        else $error("last level not updated");
`endif

endmodule
